// ===== rtl/lpfr_pkg.sv =====
// Shared types, result codes and the reset constant for the length-prefixed frame receiver.
package lpfr_pkg;

	// Widths of the channel fields
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned KIND_W = 2;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [KIND_W-1:0] kind_t;

	// Result kinds
	localparam kind_t KIND_DATA = 2'd0;
	localparam kind_t KIND_GOOD = 2'd1;
	localparam kind_t KIND_BAD  = 2'd2;
	localparam kind_t KIND_LONG = 2'd3;

	// Reset value of the maximum payload length register
	localparam len_t MAX_LENGTH_RESET = 16'd1024;

	// One result produced by the parser for one received byte
	typedef struct packed {
		logic  valid;
		kind_t kind;
		byte_t payload_byte;
		byte_t frame_command;
		len_t  frame_length;
	} lpfr_result_t;

endpackage

// ===== rtl/lpfr_if.sv =====
// Valid/ready channel interfaces for received bytes and for frame results.
interface lpfr_rx_if;
	import lpfr_pkg::*;

	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpfr_res_if;
	import lpfr_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	byte_t payload_byte;
	byte_t frame_command;
	len_t  frame_length;

	modport source (output valid, output kind, output payload_byte, output frame_command,
		output frame_length, input ready);
	modport sink (input valid, input kind, input payload_byte, input frame_command,
		input frame_length, output ready);
endinterface

// ===== rtl/length_prefixed_frame_receiver.sv =====
// Top level of the length-prefixed frame receiver: input stage, parser and result register.
//
//  Channel   Direction  Carries                                            Handshake
//  rx        sink       rx_byte                                            valid/ready
//  frame     source     kind, payload_byte, frame_command, frame_length    valid/ready
//  cfg       write      max_length (cfg_wr_en, cfg_wr_data)                enable only
//
// One byte is accepted per cycle while rx.ready is high; its result is presented from the result register.
// The byte sits in an input register, the parser handles it in one pass and the
// result goes to an output register, so throughput is set by the parser step.
// When the result register is full and not taken, the parser holds; rx.ready falls
// once the input register also holds a byte.
// Reset clears all control state and sets max_length to 1024.
module length_prefixed_frame_receiver (
	input  logic                clk,
	input  logic                arst_n,
	lpfr_rx_if.sink             rx,
	lpfr_res_if.source          frame,
	input  logic                cfg_wr_en,
	input  lpfr_pkg::len_t      cfg_wr_data
);
	import lpfr_pkg::*;

	logic         valid_s1;
	byte_t        byte_s1;
	len_t         max_length_q;
	logic         advance;
	logic         step;
	lpfr_result_t res;
	logic         out_valid_q;
	kind_t        kind_q;
	byte_t        payload_q;
	byte_t        command_q;
	len_t         length_q;

	// The pipeline moves whenever the result register is empty or being taken.
	assign advance  = !out_valid_q || frame.ready;
	assign step     = advance && valid_s1;
	assign rx.ready = !valid_s1 || advance;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg_wr_en) begin
			max_length_q <= cfg_wr_data;
		end
	end

	// Input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	lpfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (byte_s1),
		.max_length (max_length_q),
		.res        (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			kind_q    <= res.kind;
			payload_q <= res.payload_byte;
			command_q <= res.frame_command;
			length_q  <= res.frame_length;
		end
	end

	assign frame.valid         = out_valid_q;
	assign frame.kind          = kind_q;
	assign frame.payload_byte  = payload_q;
	assign frame.frame_command = command_q;
	assign frame.frame_length  = length_q;

	// The input side only stalls when the result register is full and held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> valid_s1 && out_valid_q && !frame.ready)
		else $error("input stalled without a held result");

	// A held result with a waiting byte must not let that byte be processed.
	a_no_step_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !frame.ready |=> out_valid_q && $stable(kind_q) && $stable(length_q))
		else $error("held result was overwritten");

endmodule

// ===== rtl/lpfr_parser.sv =====
// Frame parsing state machine and running checksum, one byte per step.
module lpfr_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  lpfr_pkg::byte_t       rx_byte,
	input  lpfr_pkg::len_t        max_length,
	output lpfr_pkg::lpfr_result_t res
);
	import lpfr_pkg::*;

	// Phase codes
	localparam logic [2:0] PH_CMD     = 3'd0;
	localparam logic [2:0] PH_LEN_HI  = 3'd1;
	localparam logic [2:0] PH_LEN_LO  = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_PADCNT  = 3'd4;
	localparam logic [2:0] PH_PAD     = 3'd5;
	localparam logic [2:0] PH_SUM_HI  = 3'd6;
	localparam logic [2:0] PH_SUM_LO  = 3'd7;

	logic [2:0] phase_q, phase_d;
	byte_t      command_q, command_d;
	len_t       length_q, length_d;
	len_t       byte_count_q, byte_count_d;
	byte_t      pad_count_q, pad_count_d;
	byte_t      pad_seen_q, pad_seen_d;
	len_t       sum_q, sum_d;
	byte_t      sum_hi_q, sum_hi_d;
	len_t       length_full;
	len_t       count_inc;
	byte_t      pad_inc;
	len_t       rx_sum;

	assign length_full = {length_q[LEN_W-1:BYTE_W], rx_byte};
	assign count_inc   = byte_count_q + len_t'(1);
	assign pad_inc     = pad_seen_q + byte_t'(1);
	assign rx_sum      = {sum_hi_q, rx_byte};

	// Next state and result for the byte presented this cycle
	always_comb begin
		phase_d      = phase_q;
		command_d    = command_q;
		length_d     = length_q;
		byte_count_d = byte_count_q;
		pad_count_d  = pad_count_q;
		pad_seen_d   = pad_seen_q;
		sum_d        = sum_q;
		sum_hi_d     = sum_hi_q;
		res.valid         = 1'b0;
		res.kind          = KIND_DATA;
		res.payload_byte  = '0;
		res.frame_command = command_q;
		res.frame_length  = length_q;
		unique case (phase_q)
			PH_CMD: begin
				command_d = rx_byte;
				sum_d     = len_t'(rx_byte);
				phase_d   = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_d = {rx_byte, {BYTE_W{1'b0}}};
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d         = length_full;
				res.frame_length = length_full;
				if (length_full > max_length) begin
					phase_d   = PH_CMD;
					res.valid = 1'b1;
					res.kind  = KIND_LONG;
				end else begin
					sum_d        = sum_q + length_full;
					byte_count_d = '0;
					phase_d      = (length_full == '0) ? PH_PADCNT : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				sum_d            = sum_q + len_t'(rx_byte);
				byte_count_d     = count_inc;
				if (count_inc >= length_q) begin
					phase_d = PH_PADCNT;
				end
				res.valid        = 1'b1;
				res.kind         = KIND_DATA;
				res.payload_byte = rx_byte;
			end
			PH_PADCNT: begin
				pad_count_d = rx_byte;
				pad_seen_d  = '0;
				sum_d       = sum_q + len_t'(rx_byte);
				phase_d     = (rx_byte == '0) ? PH_SUM_HI : PH_PAD;
			end
			PH_PAD: begin
				pad_seen_d = pad_inc;
				if (pad_inc >= pad_count_q) begin
					phase_d = PH_SUM_HI;
				end
			end
			PH_SUM_HI: begin
				sum_hi_d = rx_byte;
				phase_d  = PH_SUM_LO;
			end
			PH_SUM_LO: begin
				phase_d   = PH_CMD;
				res.valid = 1'b1;
				res.kind  = (rx_sum == sum_q) ? KIND_GOOD : KIND_BAD;
			end
			default: begin
				phase_d = PH_CMD;
			end
		endcase
	end

	// Parser state, advanced only when a byte is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_CMD;
			command_q    <= '0;
			length_q     <= '0;
			byte_count_q <= '0;
			pad_count_q  <= '0;
			pad_seen_q   <= '0;
			sum_q        <= '0;
			sum_hi_q     <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			command_q    <= command_d;
			length_q     <= length_d;
			byte_count_q <= byte_count_d;
			pad_count_q  <= pad_count_d;
			pad_seen_q   <= pad_seen_d;
			sum_q        <= sum_d;
			sum_hi_q     <= sum_hi_d;
		end
	end

	// A length abort only happens for a length above the limit.
	a_long_over_limit: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.kind == KIND_LONG |-> res.frame_length > max_length)
		else $error("length abort raised for an acceptable length");

	// Every frame end or abort returns the parser to the command phase.
	a_end_to_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.kind != KIND_DATA |=> phase_q == PH_CMD)
		else $error("parser did not return to the command phase after a frame end");

	// A payload byte can only be counted while the count is below the length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> byte_count_q < length_q)
		else $error("payload count reached the declared length inside the payload");

endmodule
